@@ src/at_clp_pkg.sv @@
// Shared types, character codes, keyword tables and range helpers for the
// AT command line parser. No dependencies.
package at_clp_pkg;

  // Command set and keyword storage
  localparam int unsigned NumCmd   = 7;
  localparam int unsigned KwMaxLen = 16;

  typedef enum logic [2:0] {
    CMD_TIME      = 3'd0,
    CMD_DATE      = 3'd1,
    CMD_ALARM     = 3'd2,
    CMD_HEARTBEAT = 3'd3,
    CMD_TEMP      = 3'd4,
    CMD_DUMP      = 3'd5,
    CMD_TIMELOG   = 3'd6
  } cmd_e;

  // Result status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  // Character codes
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Field limits
  localparam logic [7:0]  HourLimit   = 8'd24;
  localparam logic [7:0]  MinSecLimit = 8'd60;
  localparam logic [7:0]  MonthMax    = 8'd12;
  localparam logic [15:0] YearMax     = 16'd9999;
  localparam logic [15:0] HbMin       = 16'd50;
  localparam logic [15:0] HbMax       = 16'd1000;
  localparam int unsigned HbStep      = 50;
  localparam int unsigned HbSteps     = 20;
  localparam logic [15:0] LogMax      = 16'd720;
  localparam logic [15:0] ParamMissing = 16'hFFFF;

  // Summary of a finished line, handed from the parser to the checker
  typedef struct packed {
    logic              valid_line;  // keyword matched, no UART error
    logic [NumCmd-1:0] kw;          // one-hot keyword when valid_line
    logic [2:0][15:0]  params;      // field values, all ones when missing
  } line_sum_t;

  // One result beat
  typedef struct packed {
    logic        status;
    logic [2:0]  command;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [15:0] param_third;
  } result_t;

  // Keyword text, first character in the top byte, zero padded
  function automatic logic [7:0] kw_char(input cmd_e k, input logic [3:0] pos);
    logic [8*KwMaxLen-1:0] s;
    case (k)
      CMD_TIME:      s = {"AT+TIME", {9{8'h00}}};
      CMD_DATE:      s = {"AT+DATE", {9{8'h00}}};
      CMD_ALARM:     s = {"AT+ALARM", {8{8'h00}}};
      CMD_HEARTBEAT: s = {"AT+HEARTBEAT", {4{8'h00}}};
      CMD_TEMP:      s = {"AT+TEMP", {9{8'h00}}};
      CMD_DUMP:      s = {"AT+DUMP", {9{8'h00}}};
      CMD_TIMELOG:   s = {"AT+TIMELOG", {6{8'h00}}};
      default:       s = '0;
    endcase
    return s[8*(KwMaxLen-1-int'(pos)) +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input cmd_e k);
    logic [3:0] n;
    case (k)
      CMD_ALARM:     n = 4'd8;
      CMD_HEARTBEAT: n = 4'd12;
      CMD_TIMELOG:   n = 4'd10;
      default:       n = 4'd7;
    endcase
    return n;
  endfunction

  // Folded value divisible by 25 (covers the whole 10-bit fold range)
  function automatic logic is_mult25(input logic [9:0] x);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 41; i++) begin
      if (x == 10'(i * 25)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Heartbeat period is one of the allowed 50-step values
  function automatic logic is_hb_step(input logic [15:0] v);
    logic hit;
    hit = 1'b0;
    for (int i = 1; i <= HbSteps; i++) begin
      if (v == 16'(i * HbStep)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

@@ src/at_clp_parser.sv @@
// Per-byte line parser: keyword match, field accumulation and field commit.
// Depends on at_clp_pkg.
module at_clp_parser #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  error_i,
  output at_clp_pkg::line_sum_t sum_o
);
  import at_clp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);

  typedef enum logic [1:0] {
    PH_KEY,
    PH_MULTI,
    PH_SINGLE,
    PH_DROP
  } phase_e;

  typedef struct packed {
    logic neg;
    logic invalid;
    logic nonempty;
  } fld_flags_t;

  phase_e           phase_q, phase_d;
  logic [NumCmd-1:0] kw_q, kw_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [1:0]       idx_q, idx_d;
  logic [15:0]      acc_q, acc_d;
  fld_flags_t       flags_q, flags_d;
  logic [2:0][15:0] params_q, params_d;

  logic             is_end;
  logic [15:0]      fld_val;
  logic [15:0]      feed_acc;
  fld_flags_t       feed_flags;
  logic             is_digit;
  logic             hit_vld;
  cmd_e             hit;
  logic [2:0][15:0] eff_params;

  assign is_end   = error_i || (byte_i == ChCr);
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);

  // Value of the field under construction
  always_comb begin
    if (flags_q.invalid) begin
      fld_val = ParamMissing;
    end else if (flags_q.neg) begin
      fld_val = 16'd0 - acc_q;
    end else begin
      fld_val = acc_q;
    end
  end

  // Next accumulator and flags for one field character
  always_comb begin
    feed_acc   = acc_q;
    feed_flags = flags_q;
    if (is_digit) begin
      feed_acc = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {12'd0, byte_i[3:0]};
      feed_flags.nonempty = 1'b1;
    end else if (byte_i == ChMinus && !flags_q.nonempty) begin
      feed_flags.neg      = 1'b1;
      feed_flags.nonempty = 1'b1;
    end else begin
      feed_flags.invalid  = 1'b1;
      feed_flags.nonempty = 1'b1;
    end
  end

  // Keyword terminated by '=': live keyword whose length equals the length so far, highest index wins
  always_comb begin
    hit_vld = 1'b0;
    hit     = CMD_TIME;
    for (int k = 0; k < NumCmd; k++) begin
      if (kw_q[k] && len_q == {{(LenW-4){1'b0}}, kw_len(cmd_e'(3'(k)))}) begin
        hit_vld = 1'b1;
        hit     = cmd_e'(3'(k));
      end
    end
  end

  // Parameters as seen at the carriage return (pending field committed)
  always_comb begin
    eff_params = params_q;
    if (flags_q.nonempty && idx_q != 2'd3) begin
      eff_params[idx_q] = fld_val;
    end
  end

  assign sum_o.valid_line = !error_i && (phase_q == PH_MULTI || phase_q == PH_SINGLE);
  assign sum_o.kw         = kw_q;
  assign sum_o.params     = eff_params;

  // Next state per beat
  always_comb begin
    phase_d  = phase_q;
    kw_d     = kw_q;
    len_d    = len_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    flags_d  = flags_q;
    params_d = params_q;
    if (step_i) begin
      if (is_end) begin
        phase_d  = PH_KEY;
        kw_d     = '1;
        len_d    = '0;
        idx_d    = '0;
        acc_d    = '0;
        flags_d  = '0;
        params_d = {3{ParamMissing}};
      end else if (len_q >= LenW'(LINE_MAX)) begin
        phase_d = PH_DROP;
      end else begin
        len_d = len_q + 1'b1;
        case (phase_q)
          PH_KEY: begin
            if (byte_i == ChEq) begin
              if (hit_vld) begin
                kw_d      = '0;
                kw_d[hit] = 1'b1;
                if (hit == CMD_HEARTBEAT || hit == CMD_DUMP || hit == CMD_TIMELOG) begin
                  phase_d = PH_SINGLE;
                end else begin
                  phase_d = PH_MULTI;
                end
              end else begin
                phase_d = PH_DROP;
              end
            end else begin
              for (int k = 0; k < NumCmd; k++) begin
                if (len_q >= LenW'(KwMaxLen) ||
                    len_q >= {{(LenW-4){1'b0}}, kw_len(cmd_e'(3'(k)))} ||
                    kw_char(cmd_e'(3'(k)), len_q[3:0]) != byte_i) begin
                  kw_d[k] = 1'b0;
                end
              end
            end
          end
          PH_MULTI: begin
            if (byte_i == ChComma) begin
              if (flags_q.nonempty) begin
                if (idx_q != 2'd3) begin
                  params_d[idx_q] = fld_val;
                  idx_d           = idx_q + 1'b1;
                end
                acc_d   = '0;
                flags_d = '0;
              end
            end else begin
              acc_d   = feed_acc;
              flags_d = feed_flags;
            end
          end
          PH_SINGLE: begin
            acc_d   = feed_acc;
            flags_d = feed_flags;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_KEY;
      kw_q     <= '1;
      len_q    <= '0;
      idx_q    <= '0;
      acc_q    <= '0;
      flags_q  <= '0;
      params_q <= {3{ParamMissing}};
    end else begin
      phase_q  <= phase_d;
      kw_q     <= kw_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      acc_q    <= acc_d;
      flags_q  <= flags_d;
      params_q <= params_d;
    end
  end

`ifndef SYNTHESIS
  // A line end always returns the parser to a clean keyword phase
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_end |=> phase_q == PH_KEY && len_q == '0 && kw_q == '1)
    else $error("parser state not cleared after line end");

  // Once in a field phase exactly one keyword stays selected
  a_kw_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MULTI || phase_q == PH_SINGLE) |-> $onehot(kw_q))
    else $error("field phase without a single keyword");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(LINE_MAX))
    else $error("line length beyond limit");
`endif

endmodule

@@ src/at_clp_check.sv @@
// Range checks per command and result formatting for a finished line.
// Depends on at_clp_pkg.
module at_clp_check (
  input  at_clp_pkg::line_sum_t sum_i,
  output at_clp_pkg::result_t   res_o
);
  import at_clp_pkg::*;

  cmd_e        cmd;
  logic        found;
  logic [15:0] p0, p1, p2;
  logic [7:0]  r0, r1;
  logic [15:0] r2;
  logic        ok;
  logic [7:0]  day, month;
  logic [15:0] year;
  logic [9:0]  fold;
  logic        d25, leap, date_ok;
  logic [7:0]  max_day;

  assign p0 = sum_i.params[0];
  assign p1 = sum_i.params[1];
  assign p2 = sum_i.params[2];

  // Lowest selected keyword
  always_comb begin
    found = 1'b0;
    cmd   = CMD_TIME;
    for (int k = NumCmd - 1; k >= 0; k--) begin
      if (sum_i.kw[k]) begin
        found = 1'b1;
        cmd   = cmd_e'(3'(k));
      end
    end
  end

  // Date check; year mod 25 by folding 256 = 6 (mod 25)
  assign day   = p0[7:0];
  assign month = p1[7:0];
  assign year  = p2;
  assign fold  = {2'b00, year[13:8], 2'b00} + {3'b000, year[13:8], 1'b0}
               + {2'b00, year[7:0]};
  assign d25   = is_mult25(fold);
  assign leap  = (year[1:0] == 2'b00) && (!d25 || year[3:0] == 4'd0);

  always_comb begin
    if (month == 8'd2) begin
      max_day = leap ? 8'd29 : 8'd28;
    end else if (month inside {8'd4, 8'd6, 8'd9, 8'd11}) begin
      max_day = 8'd30;
    end else begin
      max_day = 8'd31;
    end
  end

  assign date_ok = (month >= 8'd1) && (month <= MonthMax) && (day >= 8'd1) &&
                   (year <= YearMax) && (day <= max_day);

  // Per-command field selection and limits
  always_comb begin
    r0 = '0;
    r1 = '0;
    r2 = '0;
    ok = 1'b0;
    case (cmd)
      CMD_TIME: begin
        r0 = p0[7:0]; r1 = p1[7:0]; r2 = p2;
        ok = (r0 < HourLimit) && (r1 < MinSecLimit) && (r2 < {8'd0, MinSecLimit});
      end
      CMD_DATE: begin
        r0 = p0[7:0]; r1 = p1[7:0]; r2 = p2;
        ok = date_ok;
      end
      CMD_ALARM: begin
        r0 = p0[7:0]; r1 = p1[7:0];
        ok = (r0 < HourLimit) && (r1 < MinSecLimit);
      end
      CMD_HEARTBEAT: begin
        r2 = p0;
        ok = (r2 >= HbMin) && (r2 <= HbMax) && is_hb_step(r2);
      end
      CMD_TEMP: begin
        r0 = p0[7:0]; r1 = p1[7:0];
        ok = $signed(r0) < $signed(r1);
      end
      CMD_DUMP: begin
        r0 = p0[7:0];
        ok = r0 <= 8'd1;
      end
      CMD_TIMELOG: begin
        r2 = p0;
        ok = r2 <= LogMax;
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    if (ok && found && sum_i.valid_line) begin
      res_o.status       = StatusOk;
      res_o.command      = cmd;
      res_o.param_first  = r0;
      res_o.param_second = r1;
      res_o.param_third  = r2;
    end else begin
      res_o.status       = StatusErr;
      res_o.command      = '0;
      res_o.param_first  = '0;
      res_o.param_second = '0;
      res_o.param_third  = '0;
    end
  end

endmodule

@@ src/at_clp_obuf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on at_clp_pkg.
module at_clp_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  at_clp_pkg::result_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output at_clp_pkg::result_t out_data_o
);
  import at_clp_pkg::*;

  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop         = out_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Pop first, then place the new beat in the first free slot
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_vld_d) begin
        out_d     = push_data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output register");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q)
    else $error("push into full result buffer");
`endif

endmodule

@@ src/at_command_line_parser_core.sv @@
// Top level of the AT command line parser: input register, parser, checker
// and result buffer. Depends on at_clp_pkg and the at_clp_* modules.
//
// Usage:
//   Input channel: one received UART character per beat on rx_byte_i, with
//   rx_error_i flagging a UART error (character ignored, line discarded).
//   A carriage return ends the line. Beats are taken when in_valid_i is high
//   and in_stall_o is low.
//   Output channel: one result beat per carriage return or UART error:
//   status_o (0 OK, 1 ERROR), command_o and three parameters. Taken when
//   out_valid_o is high and out_stall_i is low.
// Timing:
//   Throughput is one character per cycle while in_stall_o is low. A line end
//   leaving the input register is parsed, checked and loaded into the output
//   register, or into the skid register if the output register stays full.
//   These two registers hold up to two results; with both full, the input
//   stalls only while the character waiting in the input register ends a line.
// Reset:
//   rst_ni clears the parser to the keyword phase with no line collected and
//   empties both the input register and the result buffer.
module at_command_line_parser_core #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_error_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [2:0]  command_o,
  output logic [7:0]  param_first_o,
  output logic [7:0]  param_second_o,
  output logic [15:0] param_third_o
);
  import at_clp_pkg::*;

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       err_q;
  logic       accept;
  logic       adv;
  logic       in_is_end;
  logic       buf_full;
  line_sum_t  line_sum;
  result_t    res;
  result_t    out_data;

  // Input register handshake
  assign in_is_end  = err_q || (byte_q == ChCr);
  assign adv        = in_vld_q && (!in_is_end || !buf_full);
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
      err_q  <= rx_error_i;
    end
  end

  at_clp_parser #(
    .LINE_MAX(LINE_MAX)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (byte_q),
    .error_i(err_q),
    .sum_o  (line_sum)
  );

  at_clp_check u_check (
    .sum_i(line_sum),
    .res_o(res)
  );

  at_clp_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (adv && in_is_end),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign status_o       = out_data.status;
  assign command_o      = out_data.command;
  assign param_first_o  = out_data.param_first;
  assign param_second_o = out_data.param_second;
  assign param_third_o  = out_data.param_third;

`ifndef SYNTHESIS
  // Every processed line end shows up as a pending result next cycle
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_is_end |=> out_valid_o)
    else $error("line end without result beat");
`endif

endmodule
